>>> rtl/core/mmpq_pkg.sv
// Package for the min-max priority queue: sizes, codes, slot type and FSM states.
package mmpq_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 31;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int MEM_DEPTH  = 2 ** (IDX_W + 1);

    typedef enum logic [1:0] {
        OP_INSERT      = 2'd0,
        OP_EXTRACT_MIN = 2'd1,
        OP_EXTRACT_MAX = 2'd2,
        OP_UNUSED      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_RESERVED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      handle;
    } slot_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_HND,
        S_UP_CHK,
        S_UP_CMP,
        S_UP_FIN,
        S_EXT_ROOT,
        S_DEL_POS,
        S_DEL_P,
        S_DEL_LAST,
        S_DN_L,
        S_DN_LR,
        S_DN_R,
        S_DN_CMP,
        S_DN_END,
        S_DEL_NEXT,
        S_DONE
    } state_t;

endpackage

>>> rtl/core/min_max_priority_queue.sv
// Double-ended priority queue from a min heap and a max heap sharing one sequencer.
// An insert sifts the new entry up in each heap in turn; an extract removes the root's handle
// from both heaps, sifting the moved-in last entry down, or up if it did not move down, in each.
// Full, empty and unused-code transactions go straight to the result; a held result stalls it.
// One transaction at a time: the next is accepted once the result loads (s_ready rises with m_valid).
// Reset (synchronous, aresetn low): queue empty, free list restored, no result pending.
module min_max_priority_queue
    import mmpq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_result_value,
    output logic [1:0]            m_status
);

    // compare rule: min heap a<=b, max heap a>=b
    function automatic logic above(input logic is_max, input logic [VALUE_BITS-1:0] a,
                                   input logic [VALUE_BITS-1:0] b);
        above = is_max ? (a >= b) : (a <= b);
    endfunction

    // memories: slots and position maps for both heaps, free handle stack
    slot_t            slot_mem [MEM_DEPTH];
    logic [IDX_W-1:0] pos_mem  [MEM_DEPTH];
    logic [IDX_W-1:0] free_mem [2 ** IDX_W];

    logic             slot_we, pos_we, free_we;
    logic [IDX_W:0]   slot_wa, slot_ra, pos_wa, pos_ra;
    slot_t            slot_wd, slot_rdata;
    logic [IDX_W-1:0] pos_wd, pos_rdata, free_wa, free_ra, free_wd, free_rdata;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        slot_rdata <= slot_mem[slot_ra];
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pos_rdata <= pos_mem[pos_ra];
    end

    always_ff @(posedge aclk) begin
        if (free_we) begin
            free_mem[free_wa] <= free_wd;
        end
        free_rdata <= free_mem[free_ra];
    end

    // control and working registers
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  hp_reg, hp_next;
    logic                  second_reg, second_next;
    logic [IDX_W-1:0]      hd_reg, hd_next;
    slot_t                 cur_reg, cur_next;
    slot_t                 child_reg, child_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      par_reg, par_next;
    logic [IDX_W-1:0]      cidx_reg, cidx_next;
    logic [IDX_W-1:0]      delp_reg, delp_next;
    logic [CNT_W-1:0]      elem_cnt_reg, elem_cnt_next;
    logic [CNT_W-1:0]      free_cnt_reg, free_cnt_next;
    logic [CNT_W-1:0]      free_low_reg, free_low_next;
    logic [VALUE_BITS-1:0] res_reg, res_next;
    status_t               status_reg, status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_result_value_reg, m_result_value_next;
    logic [1:0]            m_status_reg, m_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            elem_cnt_reg <= '0;
            free_cnt_reg <= CNT_W'(CAPACITY);
            free_low_reg <= CNT_W'(CAPACITY);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            free_cnt_reg <= free_cnt_next;
            free_low_reg <= free_low_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg             <= op_next;
        val_reg            <= val_next;
        hp_reg             <= hp_next;
        second_reg         <= second_next;
        hd_reg             <= hd_next;
        cur_reg            <= cur_next;
        child_reg          <= child_next;
        idx_reg            <= idx_next;
        par_reg            <= par_next;
        cidx_reg           <= cidx_next;
        delp_reg           <= delp_next;
        res_reg            <= res_next;
        status_reg         <= status_next;
        m_result_value_reg <= m_result_value_next;
        m_status_reg       <= m_status_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_status       = m_status_reg;

    logic [CNT_W-1:0] last_cnt, free_top, left_cnt;
    assign last_cnt = elem_cnt_reg - 1'b1;
    assign free_top = free_cnt_reg - 1'b1;
    assign left_cnt = {idx_reg, 1'b1};

    // sequencer: next state, datapath updates and memory controls
    always_comb begin
        state_next          = state_reg;
        op_next             = op_reg;
        val_next            = val_reg;
        hp_next             = hp_reg;
        second_next         = second_reg;
        hd_next             = hd_reg;
        cur_next            = cur_reg;
        child_next          = child_reg;
        idx_next            = idx_reg;
        par_next            = par_reg;
        cidx_next           = cidx_reg;
        delp_next           = delp_reg;
        elem_cnt_next       = elem_cnt_reg;
        free_cnt_next       = free_cnt_reg;
        free_low_next       = free_low_reg;
        res_next            = res_reg;
        status_next         = status_reg;
        m_valid_next        = m_valid_reg;
        m_result_value_next = m_result_value_reg;
        m_status_next       = m_status_reg;
        slot_we = 1'b0;
        slot_wa = '0;
        slot_wd = cur_reg;
        slot_ra = '0;
        pos_we  = 1'b0;
        pos_wa  = '0;
        pos_wd  = idx_reg;
        pos_ra  = {hp_reg, hd_reg};
        free_we = 1'b0;
        free_wa = free_cnt_reg[IDX_W-1:0];
        free_wd = hd_reg;
        free_ra = free_top[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next     = op_t'(s_operation);
                    val_next    = s_value;
                    res_next    = '0;
                    status_next = ST_OK;
                    second_next = 1'b0;
                    unique case (op_t'(s_operation))
                        OP_INSERT: begin
                            if (elem_cnt_reg >= CNT_W'(CAPACITY) || free_cnt_reg == '0) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_INS_HND;
                            end
                        end
                        OP_EXTRACT_MIN, OP_EXTRACT_MAX: begin
                            if (elem_cnt_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                // root of the source heap
                                slot_ra    = {(op_t'(s_operation) == OP_EXTRACT_MAX),
                                              {IDX_W{1'b0}}};
                                state_next = S_EXT_ROOT;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // pop a handle; entries below the low mark were never rewritten
            S_INS_HND: begin
                hd_next       = (free_top < free_low_reg) ? free_top[IDX_W-1:0] : free_rdata;
                cur_next      = '{value: val_reg,
                                  handle: (free_top < free_low_reg) ? free_top[IDX_W-1:0]
                                                                    : free_rdata};
                free_cnt_next = free_top;
                if (free_top < free_low_reg) begin
                    free_low_next = free_top;
                end
                hp_next    = 1'b0;
                idx_next   = elem_cnt_reg[IDX_W-1:0];
                state_next = S_UP_CHK;
            end

            // sift up: fetch parent
            S_UP_CHK: begin
                if (idx_reg == '0) begin
                    state_next = S_UP_FIN;
                end else begin
                    par_next   = (idx_reg - 1'b1) >> 1;
                    slot_ra    = {hp_reg, IDX_W'((idx_reg - 1'b1) >> 1)};
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                if (above(hp_reg, slot_rdata.value, cur_reg.value)) begin
                    state_next = S_UP_FIN;
                end else begin
                    // move parent down into the hole
                    slot_we    = 1'b1;
                    slot_wa    = {hp_reg, idx_reg};
                    slot_wd    = slot_rdata;
                    pos_we     = 1'b1;
                    pos_wa     = {hp_reg, slot_rdata.handle};
                    pos_wd     = idx_reg;
                    idx_next   = par_reg;
                    state_next = S_UP_CHK;
                end
            end

            // place the moving entry at its final slot
            S_UP_FIN: begin
                slot_we = 1'b1;
                slot_wa = {hp_reg, idx_reg};
                slot_wd = cur_reg;
                pos_we  = 1'b1;
                pos_wa  = {hp_reg, cur_reg.handle};
                pos_wd  = idx_reg;
                if (op_reg == OP_INSERT) begin
                    if (!hp_reg) begin
                        hp_next    = 1'b1;
                        idx_next   = elem_cnt_reg[IDX_W-1:0];
                        state_next = S_UP_CHK;
                    end else begin
                        elem_cnt_next = elem_cnt_reg + 1'b1;
                        state_next    = S_DONE;
                    end
                end else begin
                    state_next = S_DEL_NEXT;
                end
            end

            S_EXT_ROOT: begin
                res_next   = slot_rdata.value;
                hd_next    = slot_rdata.handle;
                hp_next    = (op_reg == OP_EXTRACT_MIN);
                state_next = S_DEL_POS;
            end

            // delete handle from heap hp: look up its slot
            S_DEL_POS: begin
                pos_ra     = {hp_reg, hd_reg};
                state_next = S_DEL_P;
            end

            S_DEL_P: begin
                if ({1'b0, pos_rdata} >= last_cnt) begin
                    state_next = S_DEL_NEXT;
                end else begin
                    delp_next  = pos_rdata;
                    idx_next   = pos_rdata;
                    slot_ra    = {hp_reg, last_cnt[IDX_W-1:0]};
                    state_next = S_DEL_LAST;
                end
            end

            S_DEL_LAST: begin
                cur_next   = slot_rdata;
                state_next = S_DN_L;
            end

            // sift down: fetch left child
            S_DN_L: begin
                if (left_cnt >= last_cnt) begin
                    state_next = S_DN_END;
                end else begin
                    cidx_next  = left_cnt[IDX_W-1:0];
                    slot_ra    = {hp_reg, left_cnt[IDX_W-1:0]};
                    state_next = S_DN_LR;
                end
            end

            S_DN_LR: begin
                child_next = slot_rdata;
                if ((CNT_W'(cidx_reg) + 1'b1) < last_cnt) begin
                    slot_ra    = {hp_reg, IDX_W'(cidx_reg + 1'b1)};
                    state_next = S_DN_R;
                end else begin
                    state_next = S_DN_CMP;
                end
            end

            // pick the better child, left on a tie
            S_DN_R: begin
                if (!above(hp_reg, child_reg.value, slot_rdata.value)) begin
                    child_next = slot_rdata;
                    cidx_next  = cidx_reg + 1'b1;
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP: begin
                if (above(hp_reg, cur_reg.value, child_reg.value)) begin
                    state_next = S_DN_END;
                end else begin
                    slot_we    = 1'b1;
                    slot_wa    = {hp_reg, idx_reg};
                    slot_wd    = child_reg;
                    pos_we     = 1'b1;
                    pos_wa     = {hp_reg, child_reg.handle};
                    pos_wd     = idx_reg;
                    idx_next   = cidx_reg;
                    state_next = S_DN_L;
                end
            end

            // if nothing moved down, try sifting up from the hole
            S_DN_END: begin
                state_next = (idx_reg == delp_reg) ? S_UP_CHK : S_UP_FIN;
            end

            S_DEL_NEXT: begin
                if (!second_reg) begin
                    second_next = 1'b1;
                    hp_next     = (op_reg == OP_EXTRACT_MAX);
                    state_next  = S_DEL_POS;
                end else begin
                    elem_cnt_next = last_cnt;
                    if (free_cnt_reg < CNT_W'(CAPACITY)) begin
                        free_we       = 1'b1;
                        free_cnt_next = free_cnt_reg + 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_result_value_next = res_reg;
                    m_status_next       = status_reg;
                    state_next          = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
